// ===== rtl/tmrq_pkg.sv =====
// ----------------------------------------------------------------------------
// tmrq_pkg
// Shared types and constants of the periodic timer heap queue.
// ----------------------------------------------------------------------------
package tmrq_pkg;

  localparam int TIME_W   = 48;
  localparam int DELAY_W  = 37;
  localparam int ID_W     = 8;
  localparam int FIRE_W   = 5;
  localparam logic [FIRE_W-1:0] MAX_FIRES = 5'd16;

  // 24000 hours in milliseconds
  localparam logic [DELAY_W-1:0] RANGE_LIMIT = 37'd86400000000;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_RELEASE = 2'd2,
    ACT_NONE    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_DELAY = 2'd2,
    ST_BAD_PER   = 2'd3
  } status_t;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRED  = 1'b1;

  typedef struct packed {
    logic [TIME_W-1:0]  due;
    logic [DELAY_W-1:0] period;
    logic [ID_W-1:0]    owner;
  } entry_t;

  typedef struct packed {
    logic              kind;
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] stime;
    logic              last;
  } result_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_RESULT,
    S_UP_RD,
    S_UP_CHK,
    S_POP_RD,
    S_POP_CHK,
    S_DN_RD,
    S_DN_CHK,
    S_FIRE,
    S_FLUSH
  } state_t;

endpackage

// ===== rtl/tmrq_heap_store.sv =====
// ----------------------------------------------------------------------------
// tmrq_heap_store
// Heap slot memory: two registered read ports, one write port.
// ----------------------------------------------------------------------------
module tmrq_heap_store #(
  parameter int DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rda_en,
  input  logic [$clog2(DEPTH)-1:0]     rda_addr,
  output tmrq_pkg::entry_t             rda_data,
  input  logic                         rdb_en,
  input  logic [$clog2(DEPTH)-1:0]     rdb_addr,
  output tmrq_pkg::entry_t             rdb_data,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  tmrq_pkg::entry_t             wr_data
);

  tmrq_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rda_en) begin
      rda_data <= mem[rda_addr];
    end
    if (rdb_en) begin
      rdb_data <= mem[rdb_addr];
    end
  end

endmodule

// ===== rtl/tmrq_owner_table.sv =====
// ----------------------------------------------------------------------------
// tmrq_owner_table
// One alive bit per owner id, with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module tmrq_owner_table #(
  parameter int ID_COUNT = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  output logic                          busy,
  input  logic                          wr_en,
  input  logic [$clog2(ID_COUNT)-1:0]   wr_addr,
  input  logic                          wr_val,
  input  logic                          rd_en,
  input  logic [$clog2(ID_COUNT)-1:0]   rd_addr,
  output logic                          rd_data
);

  localparam int AW = $clog2(ID_COUNT);

  logic          mem [ID_COUNT];
  logic [AW-1:0] clr_idx;
  logic          clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      if (clr_idx == AW'(ID_COUNT - 1)) begin
        clearing <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= 1'b0;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign busy = clearing;

endmodule

// ===== rtl/periodic_timer_heap_queue.sv =====
// ----------------------------------------------------------------------------
// periodic_timer_heap_queue
// Millisecond timer queue kept as a binary min-heap in slot memory.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the action (insert, tick, release), tdata the
// owner id, first delay and repeat period. An insert answers with one status
// transaction (tuser 0, tlast 1). A tick advances time and sends one fired
// transaction (tuser 1) per due live timer, the last one with tlast set; a
// release and a tick with nothing due send nothing.
// One item is worked on at a time. The work of an insert is bounded by the
// sift-up walk through the heap memory, one read and one compare per level.
// A tick works through a pop check (a read and a check) and, per popped
// entry, a sift-down walk with one read and one compare per level, a fire
// decision and, for a periodic entry, a sift-up walk.
// At most 16 fires per tick; due entries beyond that wait for the next tick.
// After reset the owner table is swept clear while s_axis_tready stays low;
// heap and time counter start empty and at zero.
// A stalled receiver holds the output register; the block waits in place
// until the pending transaction is taken.
// ----------------------------------------------------------------------------
module periodic_timer_heap_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_COUNT    = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,   // timer_id[7:0], delay_ms[44:8], period_ms[81:45]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // status[1:0], fired_id[9:2], scheduled_time[57:10]
  output logic        m_axis_tuser,   // kind[0]
  output logic        m_axis_tlast
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int WW = IW + 2;
  localparam int AW = $clog2(ID_COUNT);
  localparam int TW = tmrq_pkg::TIME_W;
  localparam int DW = tmrq_pkg::DELAY_W;
  localparam int NW = tmrq_pkg::ID_W;

  // input fields
  logic [NW-1:0] in_id;
  logic [DW-1:0] in_delay;
  logic [DW-1:0] in_period;
  logic [NW-1:0] id_red;

  assign in_id     = s_axis_tdata[7:0];
  assign in_delay  = s_axis_tdata[44:8];
  assign in_period = s_axis_tdata[81:45];

  // owner id modulo ID_COUNT, reciprocal multiply for small counts
  generate
    if (ID_COUNT >= 256) begin : g_id_wide
      assign id_red = in_id;
    end else begin : g_id_mod
      localparam int RECIP = (65536 + ID_COUNT - 1) / ID_COUNT;
      logic [24:0] prod;
      logic [8:0]  quo;
      logic [16:0] back;
      assign prod   = 25'(in_id) * 25'(RECIP);
      assign quo    = prod[24:16];
      assign back   = 17'(quo) * 17'(ID_COUNT);
      assign id_red = in_id - back[7:0];
    end
  endgenerate

  // registers
  tmrq_pkg::state_t  state, state_next;
  logic [IW-1:0]     idx, idx_next;
  logic [CW-1:0]     count, count_next;
  logic [TW-1:0]     now, now_next;
  tmrq_pkg::entry_t  x, x_next;
  tmrq_pkg::entry_t  cur, cur_next;
  tmrq_pkg::entry_t  pend, pend_next;
  logic              pend_valid, pend_valid_next;
  logic [tmrq_pkg::FIRE_W-1:0] nfire, nfire_next;
  logic              op_tick, op_tick_next;
  tmrq_pkg::result_t ins_res, ins_res_next;
  logic              out_valid;
  tmrq_pkg::result_t out_res;

  // memory ports
  logic              rda_en, rdb_en, wr_en;
  logic [IW-1:0]     rda_addr, rdb_addr, wr_addr;
  tmrq_pkg::entry_t  rda_data, rdb_data, wr_data;
  logic              al_busy, al_wr_en, al_wr_val, al_rd_en, al_rd_data;
  logic [AW-1:0]     al_wr_addr, al_rd_addr;

  logic              out_load;
  tmrq_pkg::result_t out_load_data;
  logic              out_free;

  tmrq_heap_store #(.DEPTH(QUEUE_DEPTH)) u_heap (
    .clk      (clk),
    .rda_en   (rda_en),
    .rda_addr (rda_addr),
    .rda_data (rda_data),
    .rdb_en   (rdb_en),
    .rdb_addr (rdb_addr),
    .rdb_data (rdb_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  tmrq_owner_table #(.ID_COUNT(ID_COUNT)) u_owner (
    .clk     (clk),
    .rst     (rst),
    .busy    (al_busy),
    .wr_en   (al_wr_en),
    .wr_addr (al_wr_addr),
    .wr_val  (al_wr_val),
    .rd_en   (al_rd_en),
    .rd_addr (al_rd_addr),
    .rd_data (al_rd_data)
  );

  assign out_free = !out_valid || m_axis_tready;

  // heap index arithmetic
  logic [WW-1:0] lchild, rchild, count_w;
  logic          sel_r;
  tmrq_pkg::entry_t best;
  logic [IW-1:0] best_idx, parent;

  assign lchild   = {1'b0, idx, 1'b1};
  assign rchild   = lchild + 1'b1;
  assign count_w  = WW'(count);
  assign sel_r    = (rchild < count_w) && (rdb_data.due < rda_data.due);
  assign best     = sel_r ? rdb_data : rda_data;
  assign best_idx = sel_r ? IW'(rchild) : IW'(lchild);
  assign parent   = IW'((idx - 1'b1) >> 1);

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    count_next      = count;
    now_next        = now;
    x_next          = x;
    cur_next        = cur;
    pend_next       = pend;
    pend_valid_next = pend_valid;
    nfire_next      = nfire;
    op_tick_next    = op_tick;
    ins_res_next    = ins_res;
    rda_en          = 1'b0;
    rda_addr        = '0;
    rdb_en          = 1'b0;
    rdb_addr        = '0;
    wr_en           = 1'b0;
    wr_addr         = idx;
    wr_data         = x;
    al_wr_en        = 1'b0;
    al_wr_addr      = AW'(id_red);
    al_wr_val       = 1'b0;
    al_rd_en        = 1'b0;
    al_rd_addr      = AW'(rda_data.owner);
    out_load        = 1'b0;
    out_load_data   = ins_res;
    s_axis_tready   = 1'b0;

    case (state)
      tmrq_pkg::S_CLEAR: begin
        if (!al_busy) begin
          state_next = tmrq_pkg::S_IDLE;
        end
      end

      tmrq_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          case (tmrq_pkg::action_t'(s_axis_tuser))
            tmrq_pkg::ACT_INSERT: begin
              ins_res_next.kind  = tmrq_pkg::KIND_STATUS;
              ins_res_next.id    = id_red;
              ins_res_next.last  = 1'b1;
              ins_res_next.stime = '0;
              op_tick_next       = 1'b0;
              if (in_delay > tmrq_pkg::RANGE_LIMIT) begin
                ins_res_next.status = tmrq_pkg::ST_BAD_DELAY;
                state_next          = tmrq_pkg::S_INS_RESULT;
              end else if (in_period > tmrq_pkg::RANGE_LIMIT) begin
                ins_res_next.status = tmrq_pkg::ST_BAD_PER;
                state_next          = tmrq_pkg::S_INS_RESULT;
              end else if (count >= CW'(QUEUE_DEPTH)) begin
                ins_res_next.status = tmrq_pkg::ST_FULL;
                state_next          = tmrq_pkg::S_INS_RESULT;
              end else begin
                ins_res_next.status = tmrq_pkg::ST_OK;
                ins_res_next.stime  = now + TW'(in_delay);
                x_next.due          = now + TW'(in_delay);
                x_next.period       = in_period;
                x_next.owner        = id_red;
                idx_next            = IW'(count);
                count_next          = count + 1'b1;
                al_wr_en            = 1'b1;
                al_wr_val           = 1'b1;
                state_next          = tmrq_pkg::S_UP_RD;
              end
            end
            tmrq_pkg::ACT_TICK: begin
              now_next     = now + 1'b1;
              op_tick_next = 1'b1;
              nfire_next   = '0;
              state_next   = tmrq_pkg::S_POP_RD;
            end
            tmrq_pkg::ACT_RELEASE: begin
              al_wr_en  = 1'b1;
              al_wr_val = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end

      tmrq_pkg::S_INS_RESULT: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_load_data = ins_res;
          state_next    = tmrq_pkg::S_IDLE;
        end
      end

      // sift-up with the moving entry held in x
      tmrq_pkg::S_UP_RD: begin
        if (idx == '0) begin
          wr_en      = 1'b1;
          state_next = op_tick ? tmrq_pkg::S_POP_RD : tmrq_pkg::S_INS_RESULT;
        end else begin
          rda_en     = 1'b1;
          rda_addr   = parent;
          state_next = tmrq_pkg::S_UP_CHK;
        end
      end

      tmrq_pkg::S_UP_CHK: begin
        wr_en = 1'b1;
        if (x.due < rda_data.due) begin
          wr_data    = rda_data;
          idx_next   = parent;
          state_next = tmrq_pkg::S_UP_RD;
        end else begin
          state_next = op_tick ? tmrq_pkg::S_POP_RD : tmrq_pkg::S_INS_RESULT;
        end
      end

      tmrq_pkg::S_POP_RD: begin
        rda_en   = 1'b1;
        rda_addr = '0;
        rdb_en   = 1'b1;
        rdb_addr = IW'(count - 1'b1);
        state_next = tmrq_pkg::S_POP_CHK;
      end

      tmrq_pkg::S_POP_CHK: begin
        if (count == '0 || rda_data.due > now || nfire == tmrq_pkg::MAX_FIRES) begin
          state_next = tmrq_pkg::S_FLUSH;
        end else begin
          cur_next   = rda_data;
          count_next = count - 1'b1;
          al_rd_en   = 1'b1;
          x_next     = rdb_data;
          idx_next   = '0;
          state_next = (count > CW'(1)) ? tmrq_pkg::S_DN_RD : tmrq_pkg::S_FIRE;
        end
      end

      // sift-down of the former last entry from the root
      tmrq_pkg::S_DN_RD: begin
        if (lchild >= count_w) begin
          wr_en      = 1'b1;
          state_next = tmrq_pkg::S_FIRE;
        end else begin
          rda_en     = 1'b1;
          rda_addr   = IW'(lchild);
          rdb_en     = rchild < count_w;
          rdb_addr   = IW'(rchild);
          state_next = tmrq_pkg::S_DN_CHK;
        end
      end

      tmrq_pkg::S_DN_CHK: begin
        wr_en = 1'b1;
        if (best.due < x.due) begin
          wr_data    = best;
          idx_next   = best_idx;
          state_next = tmrq_pkg::S_DN_RD;
        end else begin
          state_next = tmrq_pkg::S_FIRE;
        end
      end

      // fired results are held one behind so the final one gets tlast
      tmrq_pkg::S_FIRE: begin
        if (!al_rd_data) begin
          state_next = tmrq_pkg::S_POP_RD;
        end else if (!pend_valid || out_free) begin
          if (pend_valid) begin
            out_load             = 1'b1;
            out_load_data.kind   = tmrq_pkg::KIND_FIRED;
            out_load_data.status = tmrq_pkg::ST_OK;
            out_load_data.id     = pend.owner;
            out_load_data.stime  = pend.due;
            out_load_data.last   = 1'b0;
          end
          pend_next       = cur;
          pend_valid_next = 1'b1;
          nfire_next      = nfire + 1'b1;
          if (cur.period != '0) begin
            x_next.due    = cur.due + TW'(cur.period);
            x_next.period = cur.period;
            x_next.owner  = cur.owner;
            idx_next      = IW'(count);
            count_next    = count + 1'b1;
            state_next    = tmrq_pkg::S_UP_RD;
          end else begin
            state_next = tmrq_pkg::S_POP_RD;
          end
        end
      end

      tmrq_pkg::S_FLUSH: begin
        if (!pend_valid) begin
          state_next = tmrq_pkg::S_IDLE;
        end else if (out_free) begin
          out_load             = 1'b1;
          out_load_data.kind   = tmrq_pkg::KIND_FIRED;
          out_load_data.status = tmrq_pkg::ST_OK;
          out_load_data.id     = pend.owner;
          out_load_data.stime  = pend.due;
          out_load_data.last   = 1'b1;
          pend_valid_next      = 1'b0;
          state_next           = tmrq_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = tmrq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tmrq_pkg::S_CLEAR;
      count      <= '0;
      now        <= '0;
      pend_valid <= 1'b0;
      nfire      <= '0;
      op_tick    <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      now        <= now_next;
      pend_valid <= pend_valid_next;
      nfire      <= nfire_next;
      op_tick    <= op_tick_next;
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    x       <= x_next;
    cur     <= cur_next;
    pend    <= pend_next;
    ins_res <= ins_res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_res <= out_load_data;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.kind;
  assign m_axis_tlast  = out_res.last;
  assign m_axis_tdata  = {6'b0, out_res.stime, out_res.id, out_res.status};

endmodule

// ===== rtl/tmrq_checker.sv =====
// ----------------------------------------------------------------------------
// tmrq_checker
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module tmrq_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // a stalled output transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");

  // an insert is a single-result item
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == tmrq_pkg::KIND_STATUS) |-> m_axis_tlast)
    else $error("insert status without tlast");

  // fired results carry no error status
  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == tmrq_pkg::KIND_FIRED) |->
      m_axis_tdata[1:0] == tmrq_pkg::ST_OK)
    else $error("fired result with nonzero status");

  // an accepted insert keeps the input closed while it is worked on
  a_insert_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == tmrq_pkg::ACT_INSERT) |=>
      !s_axis_tready)
    else $error("input ready right after an insert");

endmodule

bind periodic_timer_heap_queue tmrq_checker u_tmrq_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
